FILE: rtl/srtl_pkg.sv
// Package: shared constants, codes and control/status types of the sorted region table.
`timescale 1ns / 1ps
`default_nettype none

package srtl_pkg;

    localparam int ADDR_W              = 64;
    localparam int IDX_W               = 6;
    localparam int CNT_W               = 7;
    localparam int FLAG_W              = 2;
    localparam int ENTRY_W             = 2 * ADDR_W + FLAG_W;
    localparam int DEFAULT_TABLE_DEPTH = 64;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_FINISH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic cnt_clr;
        logic reject;
        logic lkp_mode;
        logic srch_rd;
        logic srch_step;
        logic shift_rd;
        logic shift_wr;
        logic ins_wr;
        logic res_load;
    } srtl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic cnt_full;
        logic srch_more;
        logic shift_more;
        logic ins_gt;
        logic lkp_gt;
        logic lkp_lt;
        logic out_free;
    } srtl_status_t;

endpackage

`default_nettype wire

FILE: rtl/srtl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module srtl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/srtl_ctrl.sv
// Controller: sequences clear, insert (search then shift) and lookup (binary search).
`timescale 1ns / 1ps
`default_nettype none

module srtl_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_op,
    input  wire srtl_pkg::srtl_status_t sts,
    output srtl_pkg::srtl_cmd_t       cmd
);
    import srtl_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] op_reg, op_next;
    logic       accept;

    assign accept = s_valid && (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_CLEAR;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next = s_op;
                    case (s_op)
                        OP_INSERT: state_next = sts.cnt_full ? ST_FINISH : ST_SRCH_RD;
                        OP_LOOKUP: state_next = ST_SRCH_RD;
                        default:   state_next = ST_FINISH;
                    endcase
                end
            end
            ST_SRCH_RD: begin
                if (sts.srch_more) begin
                    state_next = ST_SRCH_CMP;
                end else if (op_reg == OP_INSERT) begin
                    state_next = ST_SHIFT_RD;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_SRCH_CMP: begin
                if (op_reg == OP_LOOKUP && !sts.lkp_gt && !sts.lkp_lt) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_SRCH_RD;
                end
            end
            ST_SHIFT_RD: begin
                state_next = sts.shift_more ? ST_SHIFT_WR : ST_FINISH;
            end
            ST_SHIFT_WR: state_next = ST_SHIFT_RD;
            ST_FINISH: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd          = '0;
        cmd.lkp_mode = (op_reg == OP_LOOKUP);
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = accept;
                cmd.cnt_clr = accept && (s_op == OP_CLEAR);
                cmd.reject  = accept && (s_op == OP_INSERT) && sts.cnt_full;
            end
            ST_SRCH_RD: begin
                cmd.srch_rd = sts.srch_more;
            end
            ST_SRCH_CMP: begin
                cmd.srch_step = 1'b1;
            end
            ST_SHIFT_RD: begin
                cmd.shift_rd = sts.shift_more;
                cmd.ins_wr   = !sts.shift_more;
            end
            ST_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
            end
            ST_FINISH: begin
                cmd.res_load = sts.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/srtl_dp.sv
// Datapath: region memory, search bounds, shift pointer, entry count and result register.
`timescale 1ns / 1ps
`default_nettype none

module srtl_dp #(
    parameter int TABLE_DEPTH = srtl_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire srtl_pkg::srtl_cmd_t          cmd,
    output srtl_pkg::srtl_status_t            sts,
    input  wire logic [srtl_pkg::ADDR_W-1:0]  s_region_start,
    input  wire logic [srtl_pkg::ADDR_W-1:0]  s_region_end,
    input  wire logic                         s_is_executable,
    input  wire logic                         s_file_backed,
    input  wire logic [srtl_pkg::ADDR_W-1:0]  s_lookup_address,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_hit,
    output logic      [srtl_pkg::IDX_W-1:0]   m_found_index,
    output logic      [srtl_pkg::ADDR_W-1:0]  m_found_start,
    output logic      [srtl_pkg::ADDR_W-1:0]  m_found_end,
    output logic                              m_valid_code,
    output logic                              m_insert_rejected,
    output logic      [srtl_pkg::CNT_W-1:0]   m_entry_count
);
    import srtl_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // control state
    logic [CW-1:0]     count_reg, count_next;
    logic              m_valid_reg, m_valid_next;

    // working registers
    logic [CW-1:0]     lo_reg, lo_next;
    logic [CW-1:0]     hp_reg, hp_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [ADDR_W-1:0] key_start_reg, key_start_next;
    logic [ADDR_W-1:0] key_end_reg, key_end_next;
    logic [FLAG_W-1:0] key_flags_reg, key_flags_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              hit_reg, hit_next;
    logic [AW-1:0]     fidx_reg, fidx_next;
    logic [ADDR_W-1:0] fstart_reg, fstart_next;
    logic [ADDR_W-1:0] fend_reg, fend_next;
    logic              fvalid_reg, fvalid_next;
    logic              rej_reg, rej_next;

    // result register
    logic              m_hit_reg, m_hit_next;
    logic [IDX_W-1:0]  m_idx_reg, m_idx_next;
    logic [ADDR_W-1:0] m_start_reg, m_start_next;
    logic [ADDR_W-1:0] m_end_reg, m_end_next;
    logic              m_code_reg, m_code_next;
    logic              m_rej_reg, m_rej_next;
    logic [CNT_W-1:0]  m_cnt_reg, m_cnt_next;

    // memory and search helpers
    logic [CW:0]        mid_sum;
    logic [AW-1:0]      mid;
    logic [CW-1:0]      idx_m1;
    logic [ENTRY_W-1:0] rd_data;
    logic [ADDR_W-1:0]  rd_start;
    logic [ADDR_W-1:0]  rd_end;
    logic [FLAG_W-1:0]  rd_flags;
    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;

    // upper-bound search probes (lo+hi)/2 over [lo,hi); lookup probes over [lo,hi-1]
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hp_reg} - (CW + 1)'(cmd.lkp_mode);
    assign mid      = mid_sum[AW:1];
    assign idx_m1   = idx_reg - 1'b1;

    assign rd_start = rd_data[ADDR_W-1:0];
    assign rd_end   = rd_data[2*ADDR_W-1:ADDR_W];
    assign rd_flags = rd_data[ENTRY_W-1:2*ADDR_W];

    assign ram_rd_en   = cmd.srch_rd || cmd.shift_rd;
    assign ram_rd_addr = cmd.shift_rd ? idx_m1[AW-1:0] : mid;
    assign ram_wr_en   = cmd.shift_wr || cmd.ins_wr;
    assign ram_wr_addr = cmd.shift_wr ? idx_reg[AW-1:0] : lo_reg[AW-1:0];
    assign ram_wr_data = cmd.shift_wr ? rd_data : {key_flags_reg, key_end_reg, key_start_reg};

    srtl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        sts.cnt_full   = (count_reg == CW'(TABLE_DEPTH));
        sts.srch_more  = (lo_reg < hp_reg);
        sts.shift_more = (idx_reg > lo_reg);
        sts.ins_gt     = (rd_start > key_start_reg);
        sts.lkp_gt     = (rd_start > addr_reg);
        sts.lkp_lt     = (rd_end < addr_reg);
        sts.out_free   = !m_valid_reg || m_ready;
    end

    always_comb begin
        count_next     = count_reg;
        m_valid_next   = m_valid_reg;
        lo_next        = lo_reg;
        hp_next        = hp_reg;
        idx_next       = idx_reg;
        key_start_next = key_start_reg;
        key_end_next   = key_end_reg;
        key_flags_next = key_flags_reg;
        addr_next      = addr_reg;
        hit_next       = hit_reg;
        fidx_next      = fidx_reg;
        fstart_next    = fstart_reg;
        fend_next      = fend_reg;
        fvalid_next    = fvalid_reg;
        rej_next       = rej_reg;
        m_hit_next     = m_hit_reg;
        m_idx_next     = m_idx_reg;
        m_start_next   = m_start_reg;
        m_end_next     = m_end_reg;
        m_code_next    = m_code_reg;
        m_rej_next     = m_rej_reg;
        m_cnt_next     = m_cnt_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cmd.capture) begin
            key_start_next = s_region_start;
            key_end_next   = s_region_end;
            key_flags_next = {s_file_backed, s_is_executable};
            addr_next      = s_lookup_address;
            lo_next        = '0;
            hp_next        = count_reg;
            idx_next       = count_reg;
            hit_next       = 1'b0;
            fidx_next      = '0;
            fstart_next    = '0;
            fend_next      = '0;
            fvalid_next    = 1'b0;
            rej_next       = cmd.reject;
        end

        if (cmd.cnt_clr) begin
            count_next = '0;
        end

        if (cmd.srch_step) begin
            if (cmd.lkp_mode) begin
                if (sts.lkp_gt) begin
                    hp_next = CW'(mid);
                end else if (sts.lkp_lt) begin
                    lo_next = CW'(mid) + 1'b1;
                end else begin
                    hit_next    = 1'b1;
                    fidx_next   = mid;
                    fstart_next = rd_start;
                    fend_next   = rd_end;
                    fvalid_next = &rd_flags;
                end
            end else if (sts.ins_gt) begin
                hp_next = CW'(mid);
            end else begin
                lo_next = CW'(mid) + 1'b1;
            end
        end

        // move one entry up per write, walking down toward the insert point
        if (cmd.shift_wr) begin
            idx_next = idx_m1;
        end

        if (cmd.ins_wr) begin
            count_next = count_reg + 1'b1;
        end

        if (cmd.res_load) begin
            m_valid_next = 1'b1;
            m_hit_next   = hit_reg;
            m_idx_next   = IDX_W'(fidx_reg);
            m_start_next = fstart_reg;
            m_end_next   = fend_reg;
            m_code_next  = fvalid_reg;
            m_rej_next   = rej_reg;
            m_cnt_next   = CNT_W'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg        <= lo_next;
        hp_reg        <= hp_next;
        idx_reg       <= idx_next;
        key_start_reg <= key_start_next;
        key_end_reg   <= key_end_next;
        key_flags_reg <= key_flags_next;
        addr_reg      <= addr_next;
        hit_reg       <= hit_next;
        fidx_reg      <= fidx_next;
        fstart_reg    <= fstart_next;
        fend_reg      <= fend_next;
        fvalid_reg    <= fvalid_next;
        rej_reg       <= rej_next;
        m_hit_reg     <= m_hit_next;
        m_idx_reg     <= m_idx_next;
        m_start_reg   <= m_start_next;
        m_end_reg     <= m_end_next;
        m_code_reg    <= m_code_next;
        m_rej_reg     <= m_rej_next;
        m_cnt_reg     <= m_cnt_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_hit             = m_hit_reg;
    assign m_found_index     = m_idx_reg;
    assign m_found_start     = m_start_reg;
    assign m_found_end       = m_end_reg;
    assign m_valid_code      = m_code_reg;
    assign m_insert_rejected = m_rej_reg;
    assign m_entry_count     = m_cnt_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_insert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_wr |-> count_reg < CW'(TABLE_DEPTH))
        else $error("insert written into a full table");

    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift_wr |-> (idx_reg > lo_reg) && (idx_reg <= count_reg))
        else $error("shift write outside occupied range");

    a_probe_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.srch_step |-> (lo_reg < hp_reg) && (hp_reg <= count_reg))
        else $error("search probe outside bounds");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

FILE: rtl/sorted_range_table_lookup.sv
// Sorted region table: accepts clear / insert / lookup items and returns one result per item.
//
// Input channel s_*: valid/ready. One item at a time; s_ready is high while the block is idle,
// also while an earlier result still waits in the output register.
// Result channel m_*: valid/ready, one result item per input item, in order.
// Per item, n = entries in the table, k = binary-search probes (at most clog2(n+1)):
//   clear, unused op, rejected insert: go straight to loading the result.
//   lookup: k probes, each probe is one memory read plus one compare; a hit ends
//           the search early.
//   insert: k probes to find the insert position p, then every entry above p is
//           moved up one place by a read and a write through the single region memory.
// The next item is accepted in the cycle after its predecessor's result is loaded.
// The memory port allows one read and one write per cycle.
// Reset (aresetn low, synchronous) empties the table and drops any waiting result; the
// memory itself is not cleared, entries are only ever read below the entry count.
// When the receiver stalls, the finished result holds in the output register, the next
// item can still be accepted and is processed up to its own result, then waits.
`timescale 1ns / 1ps
`default_nettype none

module sorted_range_table_lookup #(
    parameter int TABLE_DEPTH = srtl_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [1:0]                   s_op,
    input  wire logic [srtl_pkg::ADDR_W-1:0]  s_region_start,
    input  wire logic [srtl_pkg::ADDR_W-1:0]  s_region_end,
    input  wire logic                         s_is_executable,
    input  wire logic                         s_file_backed,
    input  wire logic [srtl_pkg::ADDR_W-1:0]  s_lookup_address,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_hit,
    output logic      [srtl_pkg::IDX_W-1:0]   m_found_index,
    output logic      [srtl_pkg::ADDR_W-1:0]  m_found_start,
    output logic      [srtl_pkg::ADDR_W-1:0]  m_found_end,
    output logic                              m_valid_code,
    output logic                              m_insert_rejected,
    output logic      [srtl_pkg::CNT_W-1:0]   m_entry_count
);
    import srtl_pkg::*;

    srtl_cmd_t    cmd;
    srtl_status_t sts;

    srtl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .sts     (sts),
        .cmd     (cmd)
    );

    srtl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_region_start    (s_region_start),
        .s_region_end      (s_region_end),
        .s_is_executable   (s_is_executable),
        .s_file_backed     (s_file_backed),
        .s_lookup_address  (s_lookup_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_hit             (m_hit),
        .m_found_index     (m_found_index),
        .m_found_start     (m_found_start),
        .m_found_end       (m_found_end),
        .m_valid_code      (m_valid_code),
        .m_insert_rejected (m_insert_rejected),
        .m_entry_count     (m_entry_count)
    );

endmodule

`default_nettype wire
